>>> design/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg: shared types and constants for the chunked body decoder
// Byte classes, queue item layout, parser phases and status codes.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  localparam int unsigned COUNT_BITS_DEFAULT = 24;
  localparam int unsigned MAX_BITS           = 24;
  localparam logic [MAX_BITS-1:0] MAX_BODY_RESET = 24'd65536;
  localparam int unsigned QUEUE_DEPTH        = 2;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0b;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_OK   = 2'd1,
    ST_ERR  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    PH_LINE_START = 4'd0,
    PH_LINE_WS    = 4'd1,
    PH_AFTER_SIGN = 4'd2,
    PH_LEAD_ZERO  = 4'd3,
    PH_AFTER_X    = 4'd4,
    PH_DIGITS     = 4'd5,
    PH_SIZE_LF    = 4'd6,
    PH_DATA       = 4'd7,
    PH_DATA_CR    = 4'd8,
    PH_DATA_LF    = 4'd9,
    PH_DONE       = 4'd10,
    PH_ERROR      = 4'd11
  } phase_e;

  // Classified byte as it travels from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_ws;
    logic       is_plus;
    logic       is_zero;
    logic       is_x;
    logic       is_cr;
    logic       is_lf;
  } byte_item_t;

  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

>>> design/hcbd_front.sv
// ----------------------------------------------------------------------------
// hcbd_front: input stage of the chunked body decoder
// Registers each raw byte together with its character class.
// ----------------------------------------------------------------------------
module hcbd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               body_valid_i,
  output logic               body_stall_o,
  input  logic [7:0]         body_byte_i,
  input  logic               body_last_i,
  output logic               item_valid_o,
  input  logic               item_ready_i,
  output hcbd_pkg::byte_item_t item_o
);
  import hcbd_pkg::*;

  logic       f_valid_q, f_valid_d;
  byte_item_t f_item_q, f_item_d;
  logic       accept;
  logic [4:0] hex;

  assign body_stall_o = f_valid_q && !item_ready_i;
  assign accept       = body_valid_i && !body_stall_o;
  assign hex          = hex_decode(body_byte_i);

  always_comb begin
    f_item_d.data    = body_byte_i;
    f_item_d.last    = body_last_i;
    f_item_d.is_hex  = hex[4];
    f_item_d.hex_val = hex[3:0];
    f_item_d.is_ws   = (body_byte_i == CH_SPACE) || (body_byte_i == CH_TAB) ||
                       (body_byte_i == CH_LF) || (body_byte_i == CH_VT) ||
                       (body_byte_i == CH_FF) || (body_byte_i == CH_CR);
    f_item_d.is_plus = (body_byte_i == CH_PLUS);
    f_item_d.is_zero = (body_byte_i == CH_ZERO);
    f_item_d.is_x    = (body_byte_i == CH_X_LO) || (body_byte_i == CH_X_UP);
    f_item_d.is_cr   = (body_byte_i == CH_CR);
    f_item_d.is_lf   = (body_byte_i == CH_LF);
  end

  always_comb begin
    f_valid_d = f_valid_q;
    if (accept) begin
      f_valid_d = 1'b1;
    end else if (item_ready_i) begin
      f_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= f_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_item_q <= f_item_d;
    end
  end

  assign item_valid_o = f_valid_q;
  assign item_o       = f_item_q;

endmodule

>>> design/hcbd_queue.sv
// ----------------------------------------------------------------------------
// hcbd_queue: short queue between classifier and parser
// Small circular buffer that lets each side stall on its own.
// ----------------------------------------------------------------------------
module hcbd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  hcbd_pkg::byte_item_t push_item_i,
  output logic               ready_o,
  input  logic               pop_i,
  output logic               nonempty_o,
  output hcbd_pkg::byte_item_t pop_item_o
);
  import hcbd_pkg::*;

  localparam int unsigned PtrBits = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntBits = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrBits-1:0] LastSlot = PtrBits'(QUEUE_DEPTH - 1);

  byte_item_t         slot_q [QUEUE_DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] count_q, count_d;
  logic               do_push, do_pop;

  assign ready_o    = (count_q != CntBits'(QUEUE_DEPTH));
  assign nonempty_o = (count_q != '0);
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && nonempty_o;
  assign pop_item_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastSlot) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastSlot) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

>>> design/hcbd_back.sv
// ----------------------------------------------------------------------------
// hcbd_back: chunk parser and result register
// Walks the size-line / data / CR LF phases and registers one result per byte.
// ----------------------------------------------------------------------------
module hcbd_back #(
  parameter int unsigned COUNT_BITS = hcbd_pkg::COUNT_BITS_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               max_body_bytes_we_i,
  input  logic [hcbd_pkg::MAX_BITS-1:0] max_body_bytes_i,
  input  logic               item_valid_i,
  output logic               item_pop_o,
  input  hcbd_pkg::byte_item_t item_i,
  output logic               res_valid_o,
  input  logic               res_stall_i,
  output logic [7:0]         out_byte_o,
  output logic               out_valid_o,
  output logic [1:0]         status_o
);
  import hcbd_pkg::*;

  localparam int unsigned WideBits = (COUNT_BITS > MAX_BITS) ? COUNT_BITS : MAX_BITS;
  localparam logic [COUNT_BITS-1:0] CntOne = COUNT_BITS'(1);

  logic [MAX_BITS-1:0]   max_q;
  phase_e                phase_q, phase_d, phase_s;
  logic [COUNT_BITS-1:0] remain_q, remain_d;
  logic [COUNT_BITS-1:0] total_q, total_d;
  logic [COUNT_BITS-1:0] acc_q, acc_d;
  logic                  has_digit_q, has_digit_d;
  logic                  ovf_q, ovf_d;

  logic                  res_valid_q, res_valid_d;
  logic [7:0]            out_byte_q, out_byte_d;
  logic                  out_valid_q, out_valid_d;
  status_e               status_q, status_d;

  logic [WideBits-1:0]   max_w, limit_w;
  logic [COUNT_BITS-1:0] limit;
  logic                  size_bad;
  logic                  pop;

  assign max_w   = WideBits'(max_q);
  assign limit_w = (max_w > WideBits'({COUNT_BITS{1'b1}})) ?
                   WideBits'({COUNT_BITS{1'b1}}) : max_w;
  assign limit   = limit_w[COUNT_BITS-1:0];
  // Compare against room left; no room check when the total already exceeds the limit
  assign size_bad = (total_q <= limit) && (acc_q > (limit - total_q));

  assign pop        = item_valid_i && (!res_valid_q || !res_stall_i);
  assign item_pop_o = pop;

  always_comb begin
    phase_s     = phase_q;
    remain_d    = remain_q;
    total_d     = total_q;
    acc_d       = acc_q;
    has_digit_d = has_digit_q;
    ovf_d       = ovf_q;
    out_byte_d  = 8'd0;
    out_valid_d = 1'b0;
    if (pop) begin
      unique case (phase_q)
        PH_LINE_START, PH_LINE_WS, PH_AFTER_SIGN, PH_LEAD_ZERO,
        PH_AFTER_X, PH_DIGITS: begin
          priority if (item_i.is_ws &&
                       (phase_q == PH_LINE_START || phase_q == PH_LINE_WS)) begin
            phase_s = PH_LINE_WS;
          end else if (item_i.is_plus &&
                       (phase_q == PH_LINE_START || phase_q == PH_LINE_WS)) begin
            phase_s = PH_AFTER_SIGN;
          end else if (item_i.is_x && phase_q == PH_LEAD_ZERO) begin
            phase_s = PH_AFTER_X;
          end else if (item_i.is_hex) begin
            has_digit_d = 1'b1;
            if (!ovf_q) begin
              if (acc_q[COUNT_BITS-1:COUNT_BITS-4] != 4'd0) begin
                ovf_d = 1'b1;
              end else begin
                acc_d = {acc_q[COUNT_BITS-5:0], item_i.hex_val};
              end
            end
            phase_s = (item_i.is_zero &&
                       (phase_q == PH_LINE_START || phase_q == PH_LINE_WS ||
                        phase_q == PH_AFTER_SIGN)) ? PH_LEAD_ZERO : PH_DIGITS;
          end else if (item_i.is_cr &&
                       (phase_q == PH_LEAD_ZERO || phase_q == PH_DIGITS)) begin
            phase_s = PH_SIZE_LF;
          end else begin
            phase_s = PH_ERROR;
          end
        end
        PH_SIZE_LF: begin
          if (!item_i.is_lf || !has_digit_q || ovf_q || size_bad) begin
            phase_s = PH_ERROR;
          end else if (acc_q == '0) begin
            phase_s = PH_DONE;
          end else begin
            remain_d = acc_q;
            phase_s  = PH_DATA;
          end
        end
        PH_DATA: begin
          out_byte_d  = item_i.data;
          out_valid_d = 1'b1;
          total_d     = total_q + CntOne;
          remain_d    = remain_q - CntOne;
          if (remain_q == CntOne) begin
            phase_s = PH_DATA_CR;
          end
        end
        PH_DATA_CR: begin
          phase_s = item_i.is_cr ? PH_DATA_LF : PH_ERROR;
        end
        PH_DATA_LF: begin
          if (item_i.is_lf) begin
            acc_d       = '0;
            has_digit_d = 1'b0;
            ovf_d       = 1'b0;
            phase_s     = PH_LINE_START;
          end else begin
            phase_s = PH_ERROR;
          end
        end
        PH_DONE:  phase_s = PH_DONE;
        PH_ERROR: phase_s = PH_ERROR;
        default:  phase_s = PH_ERROR;
      endcase
    end
  end

  // Stream end settles the body: clean only at a chunk boundary
  always_comb begin
    phase_d = phase_s;
    if (pop && item_i.last && phase_s != PH_DONE && phase_s != PH_ERROR) begin
      phase_d = (phase_s == PH_LINE_START) ? PH_DONE : PH_ERROR;
    end
    unique case (phase_d)
      PH_DONE:  status_d = ST_OK;
      PH_ERROR: status_d = ST_ERR;
      default:  status_d = ST_BUSY;
    endcase
    res_valid_d = pop ? 1'b1 : (res_valid_q && res_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= MAX_BODY_RESET;
      phase_q     <= PH_LINE_START;
      remain_q    <= '0;
      total_q     <= '0;
      acc_q       <= '0;
      has_digit_q <= 1'b0;
      ovf_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (max_body_bytes_we_i) begin
        max_q <= max_body_bytes_i;
      end
      phase_q     <= phase_d;
      remain_q    <= remain_d;
      total_q     <= total_d;
      acc_q       <= acc_d;
      has_digit_q <= has_digit_d;
      ovf_q       <= ovf_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_byte_q  <= out_byte_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

endmodule

>>> design/http_chunked_body_decoder_core.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core: HTTP/1.1 chunked body decoder
// Strips chunk framing from a raw body byte stream, one result per byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel body_*: one raw body byte per item, body_last_i on the final
//   byte of the stream. Output channel res_*: exactly one result per input
//   item (out_byte_o/out_valid_o for payload bytes, status_o for progress:
//   busy, complete, error). Both channels move an item when valid is high and
//   stall is low.
//   Throughput is one item per cycle while neither channel stalls; a result
//   moves from the input register through the queue to the result register.
//   When the receiver stalls, the result register holds and the queue fills;
//   body_stall_o rises only once the queue and input register are full.
//   The size limit max_body_bytes_i is written with max_body_bytes_we_i; the user
//   must write it while no item is in flight, as the block does not enforce it.
//   Reset clears the parser to the start of a size line, zeroes the totals,
//   sets the limit to 65536 and empties the queue. After complete or error
//   the status holds until reset and later bytes give no payload.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_core #(
  parameter int unsigned COUNT_BITS = hcbd_pkg::COUNT_BITS_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               max_body_bytes_we_i,
  input  logic [hcbd_pkg::MAX_BITS-1:0] max_body_bytes_i,
  input  logic               body_valid_i,
  output logic               body_stall_o,
  input  logic [7:0]         body_byte_i,
  input  logic               body_last_i,
  output logic               res_valid_o,
  input  logic               res_stall_i,
  output logic [7:0]         out_byte_o,
  output logic               out_valid_o,
  output logic [1:0]         status_o
);
  import hcbd_pkg::*;

  byte_item_t front_item, queue_item;
  logic       front_valid, queue_ready, queue_nonempty, back_pop;

  hcbd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .body_valid_i (body_valid_i),
    .body_stall_o (body_stall_o),
    .body_byte_i  (body_byte_i),
    .body_last_i  (body_last_i),
    .item_valid_o (front_valid),
    .item_ready_i (queue_ready),
    .item_o       (front_item)
  );

  hcbd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (front_valid),
    .push_item_i (front_item),
    .ready_o     (queue_ready),
    .pop_i       (back_pop),
    .nonempty_o  (queue_nonempty),
    .pop_item_o  (queue_item)
  );

  hcbd_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .max_body_bytes_we_i (max_body_bytes_we_i),
    .max_body_bytes_i    (max_body_bytes_i),
    .item_valid_i        (queue_nonempty),
    .item_pop_o          (back_pop),
    .item_i              (queue_item),
    .res_valid_o         (res_valid_o),
    .res_stall_i         (res_stall_i),
    .out_byte_o          (out_byte_o),
    .out_valid_o         (out_valid_o),
    .status_o            (status_o)
  );

endmodule
